/* src/mpr_pkg.sv */
// ----------------------------------------------------------------------------
// mpr_pkg
// Shared types and constants of the four-motor PWM ramp controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mpr_pkg;

   localparam int MOTORS = 4;
   localparam logic [7:0] ENC_BASE = 8'd14;

   localparam logic [7:0] POWER_FLOOR_RST   = 8'd40;
   localparam logic [7:0] POWER_CEILING_RST = 8'd255;
   localparam logic [7:0] CHANGE_STEP_RST   = 8'd10;

   typedef enum logic [1:0] {
      OP_SET_SPEED = 2'd0,
      OP_SET_DIR   = 2'd1,
      OP_TICK      = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REG_POWER_FLOOR   = 2'd0,
      REG_POWER_CEILING = 2'd1,
      REG_CHANGE_STEP   = 2'd2
   } reg_type;

   typedef struct packed {
      logic [7:0] power_floor;
      logic [7:0] power_ceiling;
      logic [7:0] change_step;
   } cfg_type;

   typedef struct packed {
      logic       set_speed;
      logic       set_dir;
      logic       tick;
      logic [7:0] speed_goal;
      logic [7:0] enc_goal;
      logic       dir;
   } lane_cmd_type;

   typedef struct packed {
      logic [7:0] power;
      logic       dir;
   } lane_out_type;

endpackage

`default_nettype wire

/* src/mpr_lane.sv */
// ----------------------------------------------------------------------------
// mpr_lane
// State and combinational next-state update of one motor: goals, slew, reversal, trim.
// ----------------------------------------------------------------------------
`default_nettype none

module mpr_lane (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mpr_pkg::cfg_type      cfg,
   input  wire mpr_pkg::lane_cmd_type cmd,
   input  wire logic [15:0]           enc_speed,
   output mpr_pkg::lane_out_type      next_state
);

   logic [7:0] power_ff, power_in;
   logic       dir_ff, dir_in;
   logic [7:0] goal_ff, goal_in;
   logic [7:0] enc_goal_ff, enc_goal_in;
   logic       goal_dir_ff, goal_dir_in;

   logic [7:0]  diff_dn, diff_up;
   logic [8:0]  up_sum;
   logic [7:0]  up_val;
   logic [16:0] mag;
   logic [7:0]  trim;

   always_comb begin
      diff_dn = power_ff - goal_ff;
      diff_up = goal_ff - power_ff;
      up_sum  = {1'b0, power_ff} + {1'b0, cfg.change_step};
      up_val  = up_sum[8] ? 8'hFF : up_sum[7:0];
      if (up_val < cfg.power_floor) begin
         up_val = cfg.power_floor;
      end
      // |enc|, with the most negative code giving 32768
      mag = enc_speed[15] ? (17'h10000 - {1'b0, enc_speed}) : {1'b0, enc_speed};
      if (mag > {9'd0, enc_goal_ff}) begin
         trim = (goal_ff != 8'd0) ? goal_ff - 8'd1 : 8'd0;
      end else if (mag < {9'd0, enc_goal_ff}) begin
         trim = (goal_ff != 8'hFF) ? goal_ff + 8'd1 : goal_ff;
      end else begin
         trim = goal_ff;
      end
      if (trim < cfg.power_floor) begin
         trim = cfg.power_floor;
      end else if (trim > cfg.power_ceiling) begin
         trim = cfg.power_ceiling;
      end

      power_in    = power_ff;
      dir_in      = dir_ff;
      goal_in     = goal_ff;
      enc_goal_in = enc_goal_ff;
      goal_dir_in = goal_dir_ff;

      if (cmd.set_speed) begin
         goal_in     = cmd.speed_goal;
         enc_goal_in = cmd.enc_goal;
      end
      if (cmd.set_dir) begin
         goal_dir_in = cmd.dir;
      end
      if (cmd.tick) begin
         if (goal_dir_ff != dir_ff) begin
            // ramp to zero before the direction flips
            if (power_ff == 8'd0) begin
               dir_in = goal_dir_ff;
            end else if (power_ff < cfg.power_floor) begin
               power_in = 8'd0;
            end else begin
               power_in = (power_ff > cfg.change_step) ? power_ff - cfg.change_step : 8'd0;
            end
         end else if (goal_ff != power_ff) begin
            if (power_ff > goal_ff) begin
               power_in = (diff_dn < cfg.change_step) ? goal_ff
                                                       : power_ff - cfg.change_step;
            end else begin
               power_in = (diff_up < cfg.change_step) ? goal_ff : up_val;
            end
         end else if (enc_goal_ff != 8'd0) begin
            goal_in = trim;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff    <= 8'd0;
         dir_ff      <= 1'b0;
         goal_ff     <= 8'd0;
         enc_goal_ff <= 8'd0;
         goal_dir_ff <= 1'b0;
      end else begin
         power_ff    <= power_in;
         dir_ff      <= dir_in;
         goal_ff     <= goal_in;
         enc_goal_ff <= enc_goal_in;
         goal_dir_ff <= goal_dir_in;
      end
   end

   assign next_state.power = power_in;
   assign next_state.dir   = dir_in;

`ifndef SYNTHESIS
   a_dir_flip_at_zero: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && dir_ff != $past(dir_ff)) |-> ($past(power_ff) == 8'd0))
      else $error("direction changed while power was not zero");

   a_power_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && power_ff != $past(power_ff)) |-> $past(cmd.tick))
      else $error("power changed without a tick");

   a_goal_src: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && goal_ff != $past(goal_ff))
         |-> ($past(cmd.set_speed) || $past(cmd.tick)))
      else $error("goal power changed without set-speed or tick");
`endif

endmodule

`default_nettype wire

/* src/mpr_merge.sv */
// ----------------------------------------------------------------------------
// mpr_merge
// Gathers the lane results into the registered response, pins mapped.
// ----------------------------------------------------------------------------
`default_nettype none

module mpr_merge (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire mpr_pkg::lane_out_type lanes [mpr_pkg::MOTORS],
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [7:0]                 pwm [mpr_pkg::MOTORS],
   output logic                       dir_pin [mpr_pkg::MOTORS]
);

   logic       valid_ff, valid_in;
   logic [7:0] pwm_ff [mpr_pkg::MOTORS];
   logic       pin_ff [mpr_pkg::MOTORS];
   logic       pin_in [mpr_pkg::MOTORS];

   always_comb begin
      valid_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      for (int i = 0; i < mpr_pkg::MOTORS; i++) begin
         // even-index motors drive an inverted pin
         pin_in[i] = ((i % 2) == 1) ? lanes[i].dir : ~lanes[i].dir;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < mpr_pkg::MOTORS; i++) begin
            pwm_ff[i] <= lanes[i].power;
            pin_ff[i] <= pin_in[i];
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign pwm       = pwm_ff;
   assign dir_pin   = pin_ff;

endmodule

`default_nettype wire

/* src/motor_pwm_ramp_controller_top.sv */
// The response to an accepted request is registered and shows from the cycle after acceptance.
// Throughput: one request per cycle while no response is stalled; each lane computes its update combinationally.
// A new request is taken while a response waits, as long as that response leaves.
// Reset (synchronous): motor state cleared, registers back to 40 / 255 / 10.
// ----------------------------------------------------------------------------
// motor_pwm_ramp_controller_top
// Four-motor PWM slew limiter: one lane per motor, merged registered response.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_pwm_ramp_controller_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_op,
   input  wire logic [1:0]   req_motor,
   input  wire logic [7:0]   req_speed,
   input  wire logic         req_direction,
   input  wire logic [15:0]  req_enc_speed_0,
   input  wire logic [15:0]  req_enc_speed_1,
   input  wire logic [15:0]  req_enc_speed_2,
   input  wire logic [15:0]  req_enc_speed_3,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [7:0]        rsp_pwm_0,
   output logic [7:0]        rsp_pwm_1,
   output logic [7:0]        rsp_pwm_2,
   output logic [7:0]        rsp_pwm_3,
   output logic              rsp_dir_pin_0,
   output logic              rsp_dir_pin_1,
   output logic              rsp_dir_pin_2,
   output logic              rsp_dir_pin_3,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   mpr_pkg::cfg_type      cfg_ff, cfg_in;
   mpr_pkg::lane_cmd_type cmd [mpr_pkg::MOTORS];
   mpr_pkg::lane_out_type lanes [mpr_pkg::MOTORS];
   logic [15:0]           enc [mpr_pkg::MOTORS];
   logic [7:0]            pwm [mpr_pkg::MOTORS];
   logic                  dir_pin [mpr_pkg::MOTORS];

   logic       accept;
   logic       csr_wr;
   logic [1:0] reg_idx;
   logic [7:0] speed_goal;
   logic [7:0] enc_goal;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            mpr_pkg::REG_POWER_FLOOR:   cfg_in.power_floor   = csr_pwdata[7:0];
            mpr_pkg::REG_POWER_CEILING: cfg_in.power_ceiling = csr_pwdata[7:0];
            mpr_pkg::REG_CHANGE_STEP:   cfg_in.change_step   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         mpr_pkg::REG_POWER_FLOOR:   csr_prdata = {24'd0, cfg_ff.power_floor};
         mpr_pkg::REG_POWER_CEILING: csr_prdata = {24'd0, cfg_ff.power_ceiling};
         mpr_pkg::REG_CHANGE_STEP:   csr_prdata = {24'd0, cfg_ff.change_step};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_floor   <= mpr_pkg::POWER_FLOOR_RST;
         cfg_ff.power_ceiling <= mpr_pkg::POWER_CEILING_RST;
         cfg_ff.change_step   <= mpr_pkg::CHANGE_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = ~rsp_valid | rsp_ready;
   assign accept    = req_valid & req_ready;

   // set-speed goal, shared by all lanes; only the addressed lane takes it
   always_comb begin
      if (req_speed < cfg_ff.power_floor) begin
         speed_goal = 8'd0;
         enc_goal   = 8'd0;
      end else begin
         speed_goal = (req_speed < cfg_ff.power_ceiling) ? req_speed
                                                         : cfg_ff.power_ceiling;
         enc_goal   = {1'b0, speed_goal[7:1]} + mpr_pkg::ENC_BASE;
      end
   end

   assign enc[0] = req_enc_speed_0;
   assign enc[1] = req_enc_speed_1;
   assign enc[2] = req_enc_speed_2;
   assign enc[3] = req_enc_speed_3;

   always_comb begin
      for (int i = 0; i < mpr_pkg::MOTORS; i++) begin
         cmd[i].set_speed  = accept && (req_op == mpr_pkg::OP_SET_SPEED)
                             && (req_motor == 2'(i));
         cmd[i].set_dir    = accept && (req_op == mpr_pkg::OP_SET_DIR)
                             && (req_motor == 2'(i));
         cmd[i].tick       = accept && (req_op == mpr_pkg::OP_TICK);
         cmd[i].speed_goal = speed_goal;
         cmd[i].enc_goal   = enc_goal;
         cmd[i].dir        = req_direction;
      end
   end

   for (genvar g = 0; g < mpr_pkg::MOTORS; g++) begin : g_lane
      mpr_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .cfg        (cfg_ff),
         .cmd        (cmd[g]),
         .enc_speed  (enc[g]),
         .next_state (lanes[g])
      );
   end

   mpr_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .lanes     (lanes),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .pwm       (pwm),
      .dir_pin   (dir_pin)
   );

   assign rsp_pwm_0     = pwm[0];
   assign rsp_pwm_1     = pwm[1];
   assign rsp_pwm_2     = pwm[2];
   assign rsp_pwm_3     = pwm[3];
   assign rsp_dir_pin_0 = dir_pin[0];
   assign rsp_dir_pin_1 = dir_pin[1];
   assign rsp_dir_pin_2 = dir_pin[2];
   assign rsp_dir_pin_3 = dir_pin[3];

`ifndef SYNTHESIS
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   a_one_lane_per_set: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd[0].set_speed, cmd[1].set_speed, cmd[2].set_speed,
                  cmd[3].set_speed, cmd[0].set_dir, cmd[1].set_dir,
                  cmd[2].set_dir, cmd[3].set_dir}) <= 1)
      else $error("more than one lane addressed by one request");
`endif

endmodule

`default_nettype wire
